// File: rtl/fcr_pkg.sv
// Shared constants, types and codes for the FIR convolution reverb.
package fcr_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int TAPCNT_W = 11;
    localparam int IDX_W    = 10;
    localparam int FRAC_W   = SAMPLE_BITS - 1;
    localparam int PROD_W   = 2 * SAMPLE_BITS;
    localparam int ACC_W    = PROD_W + ADDR_W + 1;
    localparam int Q_W      = ACC_W - FRAC_W;

    localparam int S_TDATA_W = ((IDX_W + SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    // operation codes (carried on s_tuser)
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    // memory port control from the sequencer
    typedef struct packed {
        logic              hist_we;
        logic              hist_zero;
        logic [ADDR_W-1:0] hist_waddr;
        logic [ADDR_W-1:0] hist_raddr;
        logic [ADDR_W-1:0] tap_raddr;
    } mem_ctrl_t;

    // MAC control from the sequencer
    typedef struct packed {
        logic acc_clear;
        logic issue;
    } mac_ctrl_t;

endpackage

// File: rtl/fir_convolution_reverb_unit.sv
// Top level of the FIR convolution reverb: ports, memories and result register.
//
// Running FIR convolution reverb: each audio transaction on the slave stream is
// pushed into a 1024-entry circular sample history and answered with one master
// transaction carrying y[n] = sum over k < min(tap_count, 1024) of h[k]*x[n-k],
// rounded half up from Q2.30 to Q1.15 and saturated (m_tuser flags saturation).
// A load transaction (s_tuser = 1) writes one impulse-response tap and produces
// no output. Taps and history live in two 1024x16 synchronous RAMs; one MAC unit
// walks the taps at one tap per cycle. An audio transaction occupies the block
// through accept, tap walk, end-of-walk check, MAC pipeline drain and hand-off,
// which waits for a free output register. A load is taken in the idle state and
// leaves the block idle. A finished result waits in an output register, so the
// next transaction is taken while it is pending.
// After reset the history RAM is zeroed by a clearing pass over every entry,
// during which s_tready stays low. Taps are undefined until loaded. The
// tap_count register (reset 1) is written over cfg_* at any time; change it
// only while the block is idle. tap_count of 0 gives a zero output.
module fir_convolution_reverb_unit
    import fcr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // tap_index[9:0], value[25:10], zero pad
    input  logic                 s_tuser,  // operation: 0 sample, 1 tap load
    input  logic                 s_tlast,  // block_end
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_sample[15:0]
    output logic                 m_tuser,  // saturated
    output logic                 m_tlast,  // block_end_out
    // configuration: tap_count
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TAPCNT_W-1:0]  cfg_data
);

    logic [TAPCNT_W-1:0]    tap_count_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_sat_reg;
    logic                   out_last_reg;

    logic                   accept;
    logic [IDX_W-1:0]       in_index;
    logic [SAMPLE_BITS-1:0] in_value;
    logic                   tap_we;
    logic [SAMPLE_BITS-1:0] hist_wdata;
    logic [SAMPLE_BITS-1:0] tap_rdata;
    logic [SAMPLE_BITS-1:0] hist_rdata;
    logic                   slot_free;
    logic                   mac_busy;
    logic [SAMPLE_BITS-1:0] mac_result;
    logic                   mac_sat;
    logic                   res_load;
    logic                   res_last;
    mem_ctrl_t              mem_ctrl;
    mac_ctrl_t              mac_ctrl;

    assign accept   = s_tvalid & s_tready;
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W +: SAMPLE_BITS];

    // loads past the end of tap memory are dropped
    assign tap_we     = accept && (s_tuser == OP_LOAD) && (32'(in_index) < MAX_TAPS);
    assign hist_wdata = mem_ctrl.hist_zero ? '0 : in_value;

    // result register: free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAPCNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tap_count_reg <= cfg_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_sample_reg <= mac_result;
            out_sat_reg    <= mac_sat;
            out_last_reg   <= res_last;
        end
    end

    fcr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (ADDR_W'(in_index)),
        .wdata (in_value),
        .raddr (mem_ctrl.tap_raddr),
        .rdata (tap_rdata)
    );

    fcr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (mem_ctrl.hist_we),
        .waddr (mem_ctrl.hist_waddr),
        .wdata (hist_wdata),
        .raddr (mem_ctrl.hist_raddr),
        .rdata (hist_rdata)
    );

    fcr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (s_tuser),
        .block_end (s_tlast),
        .tap_count (tap_count_reg),
        .mac_busy  (mac_busy),
        .slot_free (slot_free),
        .ready     (s_tready),
        .mem_ctrl  (mem_ctrl),
        .mac_ctrl  (mac_ctrl),
        .res_load  (res_load),
        .res_last  (res_last)
    );

    fcr_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .tap_rdata  (tap_rdata),
        .hist_rdata (hist_rdata),
        .busy       (mac_busy),
        .result     (mac_result),
        .sat        (mac_sat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_sample_reg);
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/fcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fcr_mac.sv
// Multiply-accumulate datapath with rounding and output saturation.
module fcr_mac
    import fcr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mac_ctrl_t              ctrl,
    input  logic [SAMPLE_BITS-1:0] tap_rdata,
    input  logic [SAMPLE_BITS-1:0] hist_rdata,
    output logic                   busy,
    output logic [SAMPLE_BITS-1:0] result,
    output logic                   sat
);

    logic                     data_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [ACC_W-1:0]      rounded;
    logic signed [Q_W-1:0]        q;
    logic [Q_W-SAMPLE_BITS:0]     upper;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            data_vld_reg <= ctrl.issue;
            prod_vld_reg <= data_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(tap_rdata) * $signed(hist_rdata);
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = data_vld_reg | prod_vld_reg;

    // round half up, then clamp to the sample range
    always_comb
    begin
        rounded = acc_reg + (ACC_W'(1) <<< (FRAC_W - 1));
        q       = rounded[ACC_W-1:FRAC_W];
        upper   = q[Q_W-1:SAMPLE_BITS-1];
        sat     = !((&upper) || (~|upper));
        if (!sat)
        begin
            result = q[SAMPLE_BITS-1:0];
        end
        else if (q[Q_W-1])
        begin
            result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

// File: rtl/fcr_seq.sv
// Sequencer: history clear sweep, tap walk and result hand-off.
module fcr_seq
    import fcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic                block_end,
    input  logic [TAPCNT_W-1:0] tap_count,
    input  logic                mac_busy,
    input  logic                slot_free,
    output logic                ready,
    output mem_ctrl_t           mem_ctrl,
    output mac_ctrl_t           mac_ctrl,
    output logic                res_load,
    output logic                res_last
);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  taps_reg, taps_next;
    logic              bend_reg, bend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            wp_reg       <= '0;
            rd_ptr_reg   <= '0;
            clr_addr_reg <= '0;
            k_reg        <= '0;
            taps_reg     <= '0;
            bend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rd_ptr_reg   <= rd_ptr_next;
            clr_addr_reg <= clr_addr_next;
            k_reg        <= k_next;
            taps_reg     <= taps_next;
            bend_reg     <= bend_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        rd_ptr_next   = rd_ptr_reg;
        clr_addr_next = clr_addr_reg;
        k_next        = k_reg;
        taps_next     = taps_reg;
        bend_next     = bend_reg;
        ready         = 1'b0;
        res_load      = 1'b0;
        mem_ctrl      = '0;
        mac_ctrl      = '0;

        mem_ctrl.hist_raddr = rd_ptr_reg;
        mem_ctrl.tap_raddr  = k_reg[ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_ctrl.hist_we    = 1'b1;
                mem_ctrl.hist_zero  = 1'b1;
                mem_ctrl.hist_waddr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(MAX_TAPS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                ready = 1'b1;
                if (accept && op == OP_SAMPLE)
                begin
                    mem_ctrl.hist_we    = 1'b1;
                    mem_ctrl.hist_waddr = wp_reg;
                    mac_ctrl.acc_clear  = 1'b1;
                    rd_ptr_next = wp_reg;
                    k_next      = '0;
                    bend_next   = block_end;
                    taps_next   = (32'(tap_count) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                              : CNT_W'(tap_count);
                    wp_next     = (wp_reg == ADDR_W'(MAX_TAPS - 1)) ? '0
                                                                    : wp_reg + ADDR_W'(1);
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == taps_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    mac_ctrl.issue = 1'b1;
                    k_next         = k_reg + CNT_W'(1);
                    rd_ptr_next    = (rd_ptr_reg == '0) ? ADDR_W'(MAX_TAPS - 1)
                                                        : rd_ptr_reg - ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_last = bend_reg;

endmodule
